/* sv/akwt_pkg.sv */
// Shared types and codes for the address keyed wait table.
// No dependencies; used by every module of the block.
package akwt_pkg;

    localparam int PID_BITS = 8;
    localparam int OP_BITS  = 3;
    localparam int ST_BITS  = 2;
    localparam int IN_BITS  = 80;
    localparam int OUT_BITS = 16;

    localparam logic [OP_BITS-1:0] OP_ADD        = 3'd0;
    localparam logic [OP_BITS-1:0] OP_REMOVE     = 3'd1;
    localparam logic [OP_BITS-1:0] OP_REMOVE_ALL = 3'd2;
    localparam logic [OP_BITS-1:0] OP_QUERY      = 3'd3;
    localparam logic [OP_BITS-1:0] OP_WAKE       = 3'd4;

    localparam logic [ST_BITS-1:0] STATUS_OK       = 2'd0;
    localparam logic [ST_BITS-1:0] STATUS_NO_MATCH = 2'd1;
    localparam logic [ST_BITS-1:0] STATUS_FULL     = 2'd2;

    localparam logic [PID_BITS-1:0] NO_PROCESS = 8'hFF;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'b01,
        FSM_EXEC = 2'b10
    } fsm_t;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic use_pid;
        logic use_addr;
        logic del;
        logic load;
    } cell_ctrl_t;

endpackage

/* sv/akwt_cell.sv */
// One entry of the wait table row: valid bit, process and address.
// Depends on akwt_pkg; instantiated by address_keyed_wait_table.
module akwt_cell #(
    parameter int ADDRESS_BITS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  akwt_pkg::cell_ctrl_t          ctrl,
    input  logic [akwt_pkg::PID_BITS-1:0] key_pid,
    input  logic [ADDRESS_BITS-1:0]       key_addr,
    input  logic                          found_in,
    output logic                          found_out,
    output logic                          first,
    input  logic                          prev_valid,
    input  logic                          nxt_valid,
    input  logic [akwt_pkg::PID_BITS-1:0] nxt_pid,
    input  logic [ADDRESS_BITS-1:0]       nxt_addr,
    output logic                          valid,
    output logic [akwt_pkg::PID_BITS-1:0] pid,
    output logic [ADDRESS_BITS-1:0]       addr
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [akwt_pkg::PID_BITS-1:0] pid_reg;
    logic [akwt_pkg::PID_BITS-1:0] pid_next;
    logic [ADDRESS_BITS-1:0]       addr_reg;
    logic [ADDRESS_BITS-1:0]       addr_next;
    logic                          match;

    assign match = valid_reg
                   && (!ctrl.use_pid || (pid_reg == key_pid))
                   && (!ctrl.use_addr || (addr_reg == key_addr));
    assign found_out = found_in || match;
    assign first     = match && !found_in;

    always_comb
    begin
        valid_next = valid_reg;
        pid_next   = pid_reg;
        addr_next  = addr_reg;
        if (ctrl.del && found_out)
        begin
            // shift down from the neighbor above
            valid_next = nxt_valid;
            pid_next   = nxt_pid;
            addr_next  = nxt_addr;
        end
        else if (ctrl.load && !valid_reg && prev_valid)
        begin
            // append at the tail
            valid_next = 1'b1;
            pid_next   = key_pid;
            addr_next  = key_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pid_reg  <= pid_next;
        addr_reg <= addr_next;
    end

    assign valid = valid_reg;
    assign pid   = pid_reg;
    assign addr  = addr_reg;

endmodule

/* sv/address_keyed_wait_table.sv */
// Top level of the address keyed wait table: sequencer, output register, row of cells.
// Depends on akwt_pkg and akwt_cell.
//
// Waiting processes sit in a row of TABLE_DEPTH cells in arrival order, oldest
// in cell 0. Every cell compares its entry with the key of the current item at
// once; a removal shifts all entries above the oldest match down one cell.
// An item is accepted, then executed. Add and remove-all first drop each entry
// of the process, since the row drops one entry per cycle, and add then
// appends the new entry unless the row is full. The result waits in an output
// register, so the next item is taken while it is still pending; execution
// stalls only when that register is full and not being read.
module address_keyed_wait_table #(
    parameter int TABLE_DEPTH  = 64,
    parameter int ADDRESS_BITS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // operation [2:0], process_id [10:3], user_address [74:11], zero [79:75]
    input  logic [akwt_pkg::IN_BITS-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status [1:0], is_waiting [2], woken_process [10:3], zero [15:11]
    output logic [akwt_pkg::OUT_BITS-1:0] m_tdata
);

    localparam int PB = akwt_pkg::PID_BITS;

    akwt_pkg::fsm_t               state_reg;
    akwt_pkg::fsm_t               state_next;
    logic [akwt_pkg::OP_BITS-1:0] op_reg;
    logic [PB-1:0]                pid_reg;
    logic [ADDRESS_BITS-1:0]      addr_reg;
    logic                         dropped_reg;
    logic                         dropped_next;
    logic                         m_tvalid_reg;
    logic                         m_tvalid_next;
    logic [akwt_pkg::OUT_BITS-1:0] m_tdata_reg;
    logic [akwt_pkg::OUT_BITS-1:0] m_tdata_next;

    akwt_pkg::cell_ctrl_t         ctrl;
    logic                         done;
    logic                         out_free;
    logic                         accept;
    logic [akwt_pkg::ST_BITS-1:0] status;
    logic                         waiting;
    logic [PB-1:0]                woken;
    logic [PB-1:0]                first_pid;
    logic                         any_match;

    logic [TABLE_DEPTH:0]         found;
    logic [TABLE_DEPTH:0]         valid_ext;
    logic [TABLE_DEPTH:0]         prev_valid;
    logic [TABLE_DEPTH-1:0]       first;
    logic [PB-1:0]                pid_ext  [TABLE_DEPTH+1];
    logic [ADDRESS_BITS-1:0]      addr_ext [TABLE_DEPTH+1];

    assign found[0]               = 1'b0;
    assign prev_valid[0]          = 1'b1;
    assign valid_ext[TABLE_DEPTH] = 1'b0;
    assign pid_ext[TABLE_DEPTH]   = '0;
    assign addr_ext[TABLE_DEPTH]  = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        assign prev_valid[i+1] = valid_ext[i];

        akwt_cell #(
            .ADDRESS_BITS (ADDRESS_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key_pid    (pid_reg),
            .key_addr   (addr_reg),
            .found_in   (found[i]),
            .found_out  (found[i+1]),
            .first      (first[i]),
            .prev_valid (prev_valid[i]),
            .nxt_valid  (valid_ext[i+1]),
            .nxt_pid    (pid_ext[i+1]),
            .nxt_addr   (addr_ext[i+1]),
            .valid      (valid_ext[i]),
            .pid        (pid_ext[i]),
            .addr       (addr_ext[i])
        );
    end

    assign any_match = found[TABLE_DEPTH];

    always_comb
    begin
        first_pid = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            first_pid = first_pid | ({PB{first[i]}} & pid_ext[i]);
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == akwt_pkg::FSM_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        ctrl         = '0;
        done         = 1'b0;
        status       = akwt_pkg::STATUS_OK;
        waiting      = 1'b0;
        woken        = akwt_pkg::NO_PROCESS;
        dropped_next = dropped_reg;
        case (op_reg)
            akwt_pkg::OP_ADD:
            begin
                ctrl.use_pid = 1'b1;
                if (any_match)
                begin
                    ctrl.del = 1'b1;
                end
                else
                begin
                    done = out_free;
                    if (valid_ext[TABLE_DEPTH-1])
                    begin
                        status = akwt_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        ctrl.load = out_free;
                    end
                end
            end
            akwt_pkg::OP_REMOVE:
            begin
                ctrl.use_pid  = 1'b1;
                ctrl.use_addr = 1'b1;
                ctrl.del      = any_match && out_free;
                done          = out_free;
                status        = any_match ? akwt_pkg::STATUS_OK : akwt_pkg::STATUS_NO_MATCH;
            end
            akwt_pkg::OP_REMOVE_ALL:
            begin
                ctrl.use_pid = 1'b1;
                if (any_match)
                begin
                    ctrl.del     = 1'b1;
                    dropped_next = 1'b1;
                end
                else
                begin
                    done   = out_free;
                    status = dropped_reg ? akwt_pkg::STATUS_OK : akwt_pkg::STATUS_NO_MATCH;
                end
            end
            akwt_pkg::OP_QUERY:
            begin
                ctrl.use_pid  = 1'b1;
                ctrl.use_addr = 1'b1;
                done          = out_free;
                waiting       = any_match;
            end
            akwt_pkg::OP_WAKE:
            begin
                ctrl.use_addr = 1'b1;
                ctrl.del      = any_match && out_free;
                done          = out_free;
                status        = any_match ? akwt_pkg::STATUS_OK : akwt_pkg::STATUS_NO_MATCH;
                woken         = any_match ? first_pid : akwt_pkg::NO_PROCESS;
            end
            default:
            begin
                done = out_free;
            end
        endcase
        if (state_reg != akwt_pkg::FSM_EXEC)
        begin
            ctrl = '0;
            done = 1'b0;
        end
        if (accept)
        begin
            dropped_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            akwt_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = akwt_pkg::FSM_EXEC;
                end
            end
            akwt_pkg::FSM_EXEC:
            begin
                if (done)
                begin
                    state_next    = akwt_pkg::FSM_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, woken, waiting, status};
                end
            end
            default:
            begin
                state_next = akwt_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= akwt_pkg::FSM_IDLE;
            m_tvalid_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            dropped_reg  <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        if (accept)
        begin
            op_reg   <= s_tdata[2:0];
            pid_reg  <= s_tdata[10:3];
            addr_reg <= s_tdata[11 +: ADDRESS_BITS];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* sv/akwt_checker.sv */
// Port-level checks for the address keyed wait table, bound to the top level.
// Depends on akwt_pkg and address_keyed_wait_table.
module akwt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [akwt_pkg::OUT_BITS-1:0] m_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // block further input while an item executes
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken during execution");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3) && (m_tdata[15:11] == 5'd0))
        else $error("illegal status or padding");

    // query result carries no wake result
    a_query_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |->
            (m_tdata[1:0] == akwt_pkg::STATUS_OK) && (m_tdata[10:3] == akwt_pkg::NO_PROCESS))
        else $error("query result mixed with other fields");

endmodule

bind address_keyed_wait_table akwt_checker u_akwt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
